[rtl/core/kmm_pkg.sv]
`default_nettype none

package kmm_pkg;

	// Default message-length wrap for the byte position
	localparam int unsigned KMM_MAX_LENGTH = 65536;

	// Configuration register indexes
	localparam logic [1:0] CFG_TOTAL_LENGTH = 2'd0;
	localparam logic [1:0] CFG_SKIP_START   = 2'd1;
	localparam logic [1:0] CFG_SKIP_COUNT   = 2'd2;

	// Additive constant of the second lane
	localparam logic [63:0] KMM_LANE1_ADD = 64'h9E3779B97F4A7C15;

	// Request into and response out of the shared 64-bit multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] c;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mul_rsp_t;

	// Initial lane values
	function automatic logic [63:0] lane_init(input logic [1:0] k);
		logic [63:0] v;
		unique case (k)
			2'd0: v = 64'h243F6A8885A308D3;
			2'd1: v = 64'h13198A2E03707344;
			2'd2: v = 64'hA4093822299F31D0;
			default: v = 64'h082EFA98EC4E6C89;
		endcase
		return v;
	endfunction

	// Per-lane multiplier constant
	function automatic logic [63:0] mul_const(input logic [1:0] k);
		logic [63:0] v;
		unique case (k)
			2'd0: v = 64'h00000100000001B3;
			2'd1: v = 64'hC2B2AE3D27D4EB4F;
			2'd2: v = 64'h165667B19E3779F9;
			default: v = 64'h9E3779B185EBCA87;
		endcase
		return v;
	endfunction

	// Per-lane fixed left rotation
	function automatic logic [63:0] rotl_lane(input logic [63:0] x, input logic [1:0] k);
		logic [63:0] v;
		unique case (k)
			2'd0: v = {x[58:0], x[63:59]};
			2'd1: v = {x[52:0], x[63:53]};
			2'd2: v = {x[46:0], x[63:47]};
			default: v = {x[40:0], x[63:41]};
		endcase
		return v;
	endfunction

	// Key ROM, indexed by position mod 32
	function automatic logic [7:0] key_byte(input logic [4:0] i);
		logic [7:0] v;
		unique case (i)
			5'd0:  v = 8'h2d;
			5'd1:  v = 8'h91;
			5'd2:  v = 8'h43;
			5'd3:  v = 8'ha7;
			5'd4:  v = 8'h5c;
			5'd5:  v = 8'he1;
			5'd6:  v = 8'h18;
			5'd7:  v = 8'h6f;
			5'd8:  v = 8'hb2;
			5'd9:  v = 8'h09;
			5'd10: v = 8'hd4;
			5'd11: v = 8'h73;
			5'd12: v = 8'h8a;
			5'd13: v = 8'h35;
			5'd14: v = 8'hc6;
			5'd15: v = 8'h1e;
			5'd16: v = 8'h57;
			5'd17: v = 8'hfa;
			5'd18: v = 8'h24;
			5'd19: v = 8'h80;
			5'd20: v = 8'h6a;
			5'd21: v = 8'hbd;
			5'd22: v = 8'h11;
			5'd23: v = 8'hce;
			5'd24: v = 8'h98;
			5'd25: v = 8'h4f;
			5'd26: v = 8'he3;
			5'd27: v = 8'h2a;
			5'd28: v = 8'h75;
			5'd29: v = 8'h0c;
			5'd30: v = 8'hb9;
			default: v = 8'h61;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/core/kmm_mul64.sv]
`default_nettype none

// Low 64 bits of a 64x64 product from one 32x32 multiplier, computed sequentially
module kmm_mul64 import kmm_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic        busy_q;
	logic [1:0]  step_q;
	logic [63:0] a_q;
	logic [63:0] c_q;
	logic [63:0] acc_q;
	logic [63:0] prod_s1;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] mul_p;

	// Select the partial product: lo*lo, hi*lo, lo*hi
	assign mul_x = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
	assign mul_y = (step_q == 2'd2) ? c_q[63:32] : c_q[31:0];
	assign mul_p = mul_x * mul_y;

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
		end else if (busy_q) begin
			if (step_q == 2'd3) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 2'd1;
		end
	end

	// Latch operands, register the product, accumulate the cross terms
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			c_q <= req.c;
		end
		prod_s1 <= mul_p;
		if (busy_q && step_q == 2'd1) begin
			acc_q <= prod_s1;
		end else if (busy_q && step_q == 2'd2) begin
			acc_q[63:32] <= acc_q[63:32] + prod_s1[31:0];
		end
	end

	assign rsp.done    = busy_q && (step_q == 2'd3);
	assign rsp.product = {acc_q[63:32] + prod_s1[31:0], acc_q[31:0]};

endmodule

`default_nettype wire

[rtl/core/keyed_mix_mac_256_unit.sv]
`default_nettype none

// Keyed 256-bit byte-mixing MAC.
// Input channel: one message byte per transfer (in_valid / in_stall).
// Output channel: four 64-bit digest words per message, word_index 0..3,
// last_word on the fourth (out_valid / out_stall).
// Config port: cfg_we, cfg_index, cfg_data; write only while idle.
// A byte that is mixed runs the four lanes in chain order, each lane passing
// through an operand state (ST_PREP) and the shared 32x32 multiplier (ST_MUL),
// then a closing state (ST_FINISH); the next byte is taken back in idle.
// A byte inside the skip window is not mixed and only passes the closing state.
// After the byte at position total_length-1 the four words follow from the
// cycle after the closing cycle, one per cycle while out_stall is low;
// a stall holds the current word. No byte is taken until the fourth word
// is transferred, after which lanes and position return to initial values.
// Reset sets total_length to 1, the skip window to empty, the lanes to
// their initial constants and the position to zero.
module keyed_mix_mac_256_unit import kmm_pkg::*; #(
	parameter int unsigned MAX_LENGTH = KMM_MAX_LENGTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam logic [15:0] PosLast = 16'(MAX_LENGTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [15:0] total_length_q;
	logic [15:0] skip_start_q;
	logic [15:0] skip_count_q;
	logic [15:0] pos_q;
	logic [63:0] lanes_q [4];
	logic [1:0]  lane_q;
	logic        at_end_q;
	logic [7:0]  byte_q;

	logic        in_xfer;
	logic        out_xfer;
	logic [16:0] win_end;
	logic        skipped;
	logic        at_end;
	logic [7:0]  key;
	logic [15:0] remain;
	logic [63:0] term;
	logic [63:0] prev;
	logic [63:0] mix_x;
	mul_req_t    mul_req;
	mul_rsp_t    mul_rsp;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Skip window and end-of-message tests at the current position
	assign win_end = {1'b0, skip_start_q} + {1'b0, skip_count_q};
	assign skipped = (pos_q >= skip_start_q) && ({1'b0, pos_q} < win_end);
	assign at_end  = (pos_q == total_length_q - 16'd1);

	// Lane operand: current lane sits at slot 0, the one just mixed at slot 3
	assign key    = key_byte(pos_q[4:0]);
	assign remain = total_length_q - pos_q;

	always_comb begin
		unique case (lane_q)
			2'd0: term = 64'(byte_q) + 64'(key) + 64'(pos_q);
			2'd1: term = 64'(byte_q) + KMM_LANE1_ADD;
			2'd2: term = 64'(byte_q) << pos_q[2:0];
			default: term = 64'(key) + 64'(remain);
		endcase
	end

	assign prev  = (lane_q == 2'd0) ? 64'd0 : lanes_q[3];
	assign mix_x = lanes_q[0] ^ (prev + term);

	assign mul_req.start = (state_q == ST_PREP);
	assign mul_req.a     = mix_x;
	assign mul_req.c     = mul_const(lane_q);

	kmm_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q <= 16'd1;
			skip_start_q   <= 16'd0;
			skip_count_q   <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL_LENGTH: total_length_q <= cfg_data;
				CFG_SKIP_START:   skip_start_q   <= cfg_data;
				CFG_SKIP_COUNT:   skip_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the byte on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q <= data_byte;
		end
	end

	// Sequencer: lanes rotate one slot per mixed lane and per emitted word before the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= 16'd0;
			lane_q   <= 2'd0;
			at_end_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				lanes_q[k] <= lane_init(2'(k));
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						at_end_q <= at_end;
						lane_q   <= 2'd0;
						state_q  <= skipped ? ST_FINISH : ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_rsp.done) begin
						lanes_q[0] <= lanes_q[1];
						lanes_q[1] <= lanes_q[2];
						lanes_q[2] <= lanes_q[3];
						lanes_q[3] <= rotl_lane(mul_rsp.product, lane_q);
						lane_q     <= lane_q + 2'd1;
						state_q    <= (lane_q == 2'd3) ? ST_FINISH : ST_PREP;
					end
				end
				ST_FINISH: begin
					if (at_end_q) begin
						lane_q  <= 2'd0;
						state_q <= ST_EMIT;
					end else begin
						pos_q   <= (pos_q == PosLast) ? 16'd0 : pos_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						lane_q <= lane_q + 2'd1;
						if (lane_q == 2'd3) begin
							for (int k = 0; k < 4; k++) begin
								lanes_q[k] <= lane_init(2'(k));
							end
							pos_q   <= 16'd0;
							state_q <= ST_IDLE;
						end else begin
							lanes_q[0] <= lanes_q[1];
							lanes_q[1] <= lanes_q[2];
							lanes_q[2] <= lanes_q[3];
							lanes_q[3] <= lanes_q[0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = lanes_q[0];
	assign word_index  = lane_q;
	assign last_word   = (lane_q == 2'd3);

endmodule

`default_nettype wire

[rtl/core/kmm_checker.sv]
`default_nettype none

module kmm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [63:0] digest_word,
	input wire [1:0]  word_index,
	input wire        last_word
);

	// No byte is taken while digest words are pending
	a_busy_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("byte input ready during digest output");

	// A byte transfer makes the block busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready right after a byte transfer");

	// A stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word)
			&& $stable(word_index))
		else $error("stalled digest word changed");

	// Words come in index order without gaps
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_word |=>
			out_valid && word_index == 2'($past(word_index) + 2'd1))
		else $error("digest word index out of order");

	// The last word returns the block to idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_word |=> !out_valid && !in_stall)
		else $error("block not idle after final digest word");

endmodule

bind keyed_mix_mac_256_unit kmm_checker u_kmm_checker (.*);

`default_nettype wire
